### src/assert_macros.svh
// Assertion helpers shared by the cipher modules.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_SYNC(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/bkt_pkg.sv
// ----------------------------------------------------------------------------
// bkt_pkg
// Types, constants and helpers for the block transposition cipher.
// ----------------------------------------------------------------------------
package bkt_pkg;

    localparam int MaxBlock   = 9;
    localparam int KeyEntries = 9;
    localparam int KeyW       = 4 * KeyEntries;
    localparam int LenW       = 4;

    localparam logic ModeEnc = 1'b0;
    localparam logic ModeDec = 1'b1;

    localparam logic [1:0] CfgMode = 2'd0;
    localparam logic [1:0] CfgLen  = 2'd1;
    localparam logic [1:0] CfgKey  = 2'd2;
    localparam logic [1:0] CfgPad  = 2'd3;

    localparam logic [LenW-1:0] LenReset = 4'd9;
    localparam logic [7:0]      PadReset = 8'd120;

    typedef logic [MaxBlock-1:0][7:0] t_block;

    // One finished block (or one length error) handed to the back end.
    typedef struct packed {
        t_block            blk;
        logic [KeyW-1:0]   key;
        logic [7:0]        pad;
        logic [LenW-1:0]   len;
        logic              mode;
        logic              msg_end;
        logic              err;
    } t_job;

    // Key entry idx; entries beyond the key read as an invalid position.
    function automatic logic [3:0] key_at(input logic [KeyW-1:0] key,
                                          input logic [LenW-1:0] idx);
        logic [3:0] pos;
        pos = 4'hF;
        if (idx < LenW'(KeyEntries)) pos = key[idx*4 +: 4];
        return pos;
    endfunction

    // Effective block length: zero taken as one, saturated at the buffer size.
    function automatic logic [LenW-1:0] eff_len(input logic [LenW-1:0] len);
        logic [LenW-1:0] n;
        n = len;
        if (len == '0) n = LenW'(1);
        else if (len > LenW'(MaxBlock)) n = LenW'(MaxBlock);
        return n;
    endfunction

endpackage

### src/bkt_front.sv
// ----------------------------------------------------------------------------
// bkt_front
// Gathers input bytes into the block buffer and hands finished blocks on.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bkt_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_ready,
    input  logic [7:0]                i_byte,
    input  logic                      i_end,
    input  logic                      i_mode,
    input  logic [bkt_pkg::LenW-1:0]  i_len,
    input  logic [bkt_pkg::KeyW-1:0]  i_key,
    input  logic [7:0]                i_pad,
    input  logic                      i_q_full,
    output logic                      o_push,
    output bkt_pkg::t_job             o_job
);

    bkt_pkg::t_block            r_buf;
    bkt_pkg::t_block            n_buf;
    logic [bkt_pkg::LenW-1:0]   r_fill;
    logic [bkt_pkg::LenW-1:0]   n_fill;

    logic [bkt_pkg::LenW-1:0]   len;
    logic [bkt_pkg::LenW-1:0]   fill_inc;
    logic [3:0]                 kpos;
    logic [3:0]                 wr_addr;
    logic                       wr_en;
    logic                       accept;
    logic                       done;
    logic                       err;

    assign len      = bkt_pkg::eff_len(i_len);
    assign fill_inc = r_fill + 1'b1;
    assign kpos     = bkt_pkg::key_at(i_key, r_fill);
    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;

    always_comb begin
        // a new block starts out as all padding
        n_buf = (r_fill == '0) ? {bkt_pkg::MaxBlock{i_pad}} : r_buf;
        if (i_mode == bkt_pkg::ModeEnc) begin
            wr_addr = r_fill;
            wr_en   = r_fill < len;
        end else begin
            wr_addr = kpos;
            wr_en   = (r_fill < len) && (kpos < len);
        end
        if (wr_en) n_buf[wr_addr] = i_byte;

        err = 1'b0;
        if (i_mode == bkt_pkg::ModeEnc) begin
            done = (fill_inc >= len) || i_end;
        end else if (fill_inc < len) begin
            done = i_end;
            err  = 1'b1;
        end else begin
            done = 1'b1;
        end

        n_fill = r_fill;
        if (accept) n_fill = done ? '0 : fill_inc;
    end

    assign o_push        = accept && done;
    assign o_job.blk     = n_buf;
    assign o_job.key     = i_key;
    assign o_job.pad     = i_pad;
    assign o_job.len     = len;
    assign o_job.mode    = i_mode;
    assign o_job.msg_end = i_end;
    assign o_job.err     = err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else begin
            r_fill <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) r_buf <= n_buf;
    end

    `ASSERT_SYNC(a_fill_range, r_fill < bkt_pkg::LenW'(bkt_pkg::MaxBlock),
                 "fill count beyond block buffer")

endmodule

### src/bkt_queue.sv
// ----------------------------------------------------------------------------
// bkt_queue
// Two-entry queue of finished blocks between the front and back ends.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bkt_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  bkt_pkg::t_job  i_job,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output bkt_pkg::t_job  o_job
);

    bkt_pkg::t_job  r_mem [2];
    logic           r_wr_ptr;
    logic           r_rd_ptr;
    logic [1:0]     r_count;
    logic [1:0]     n_count;

    assign o_full  = r_count == 2'd2;
    assign o_empty = r_count == 2'd0;
    assign o_job   = r_mem[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        case ({i_push, i_pop})
            2'b10:   n_count = r_count + 2'd1;
            2'b01:   n_count = r_count - 2'd1;
            default: n_count = r_count;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) r_wr_ptr <= !r_wr_ptr;
            if (i_pop)  r_rd_ptr <= !r_rd_ptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wr_ptr] <= i_job;
    end

    `ASSERT_SYNC(a_no_overflow, i_push |-> !o_full, "push into full queue")
    `ASSERT_SYNC(a_no_underflow, i_pop |-> !o_empty, "pop from empty queue")

endmodule

### src/bkt_back.sv
// ----------------------------------------------------------------------------
// bkt_back
// Takes finished blocks off the queue and sends them out one byte a cycle while the receiver is ready.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bkt_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  bkt_pkg::t_job  i_job,
    output logic           o_pop,
    output logic           o_m_tvalid,
    input  logic           i_m_tready,
    output logic [7:0]     o_m_tdata,
    output logic           o_m_tlast,
    output logic [2:0]     o_m_tuser
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state                     r_state;
    t_state                     n_state;
    bkt_pkg::t_job              r_job;
    logic [bkt_pkg::LenW-1:0]   r_count;
    logic [bkt_pkg::LenW-1:0]   n_count;
    logic [bkt_pkg::LenW-1:0]   r_idx;
    logic [bkt_pkg::LenW-1:0]   n_idx;

    logic                       r_out_valid;
    logic [7:0]                 r_out_byte;
    logic                       r_out_bv;
    logic                       r_out_last;
    logic                       r_out_done;
    logic                       r_out_err;

    logic                       slot_free;
    logic                       emit;
    logic [3:0]                 kpos;
    logic [7:0]                 sel_byte;
    logic                       is_last;

    assign slot_free = !r_out_valid || i_m_tready;
    assign emit      = (r_state == S_EMIT) && slot_free;
    assign o_pop     = (r_state == S_IDLE) && !i_empty;
    assign kpos      = bkt_pkg::key_at(r_job.key, r_idx);
    assign is_last   = (r_count == '0) || (r_idx + 1'b1 == r_count);

    always_comb begin
        if (r_job.mode == bkt_pkg::ModeEnc) begin
            sel_byte = (kpos < r_job.len) ? r_job.blk[kpos] : r_job.pad;
        end else begin
            sel_byte = r_job.blk[r_idx];
        end
    end

    // Result count: a full block, zero for a length error, or on the final decrypt
    // block the part before the trailing padding.
    always_comb begin
        n_count = r_job.len;
        if (r_job.err) begin
            n_count = '0;
        end else if (r_job.mode == bkt_pkg::ModeDec && r_job.msg_end) begin
            n_count = '0;
            for (int i = 0; i < bkt_pkg::MaxBlock; i++) begin
                if (bkt_pkg::LenW'(i) < r_job.len && r_job.blk[i] != r_job.pad)
                    n_count = bkt_pkg::LenW'(i + 1);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        case (r_state)
            S_IDLE: begin
                if (!i_empty) n_state = S_SCAN;
            end
            S_SCAN: begin
                n_idx   = '0;
                n_state = S_EMIT;
            end
            S_EMIT: begin
                if (emit) begin
                    n_idx = r_idx + 1'b1;
                    if (is_last) n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit)            r_out_valid <= 1'b1;
            else if (i_m_tready) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) r_job <= i_job;
        if (r_state == S_SCAN) r_count <= n_count;
        r_idx <= n_idx;
        if (emit) begin
            r_out_bv   <= r_count != '0;
            r_out_byte <= (r_count != '0) ? sel_byte : 8'd0;
            r_out_last <= is_last;
            r_out_done <= is_last && r_job.msg_end;
            r_out_err  <= (r_count == '0) && r_job.err;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_byte;
    assign o_m_tlast  = r_out_last;
    assign o_m_tuser  = {r_out_err, r_out_done, r_out_bv};

    `ASSERT_SYNC(a_empty_closes, (o_m_tvalid && !o_m_tuser[0]) |->
                 (o_m_tlast && o_m_tuser[1]), "empty result not final")
    `ASSERT_NEXT(a_pop_scans, o_pop, r_state == S_SCAN, "popped job not scanned")
    `ASSERT_SYNC(a_idx_range, (r_state == S_EMIT) |->
                 (r_idx < bkt_pkg::LenW'(bkt_pkg::MaxBlock)), "index past block")

endmodule

### src/block_transposition_cipher.sv
// ----------------------------------------------------------------------------
// block_transposition_cipher
// Columnar transposition cipher over blocks of up to nine bytes.
// ----------------------------------------------------------------------------
// Usage:
// Input stream (i_s_*): one byte per transfer, tlast marks the last byte of
// a message. Output stream (o_m_*): one result per transfer, tlast marks the
// last result caused by one input byte.
// Configuration: write cipher mode, block length, key and pad byte through
// i_cfg_we / i_cfg_index / i_cfg_data while the block is idle.
// The byte that closes a block (or a message) passes the queue, the job register,
// the scan state and the output register before its first result appears.
// Throughput: the front takes one byte per cycle while the queue is not full;
// the back end pops a block, scans it, then sends one result a cycle from a
// single output register while the receiver is ready.
// A two-block queue between front and back lets input keep flowing while a
// block is sent out; o_s_tready drops only when the queue is full.
// Reset clears the fill count, the queue and the output register, and loads
// the configuration reset values. A stalled receiver holds the result in the
// output register and backs up the queue, then the input.
// ----------------------------------------------------------------------------
module block_transposition_cipher (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_s_tvalid,
    output logic                      o_s_tready,
    input  logic [7:0]                i_s_tdata,   // [7:0] data_byte
    input  logic                      i_s_tlast,   // message_end
    output logic                      o_m_tvalid,
    input  logic                      i_m_tready,
    output logic [7:0]                o_m_tdata,   // [7:0] out_byte
    output logic                      o_m_tlast,   // run_last
    output logic [2:0]                o_m_tuser,   // [0] byte_valid [1] message_done
                                                   // [2] length_error
    input  logic                      i_cfg_we,
    input  logic [1:0]                i_cfg_index,
    input  logic [bkt_pkg::KeyW-1:0]  i_cfg_data
);

    logic                       r_mode;
    logic [bkt_pkg::LenW-1:0]   r_len;
    logic [bkt_pkg::KeyW-1:0]   r_key;
    logic [7:0]                 r_pad;

    logic                       q_full;
    logic                       q_empty;
    logic                       q_push;
    logic                       q_pop;
    bkt_pkg::t_job              push_job;
    bkt_pkg::t_job              head_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= bkt_pkg::ModeEnc;
            r_len  <= bkt_pkg::LenReset;
            r_key  <= '0;
            r_pad  <= bkt_pkg::PadReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                bkt_pkg::CfgMode: r_mode <= i_cfg_data[0];
                bkt_pkg::CfgLen:  r_len  <= i_cfg_data[bkt_pkg::LenW-1:0];
                bkt_pkg::CfgKey:  r_key  <= i_cfg_data;
                bkt_pkg::CfgPad:  r_pad  <= i_cfg_data[7:0];
                default:          r_mode <= r_mode;
            endcase
        end
    end

    bkt_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_byte   (i_s_tdata),
        .i_end    (i_s_tlast),
        .i_mode   (r_mode),
        .i_len    (r_len),
        .i_key    (r_key),
        .i_pad    (r_pad),
        .i_q_full (q_full),
        .o_push   (q_push),
        .o_job    (push_job)
    );

    bkt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_job   (head_job)
    );

    bkt_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_empty    (q_empty),
        .i_job      (head_job),
        .o_pop      (q_pop),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .o_m_tuser  (o_m_tuser)
    );

endmodule
